// ===== rtl/booth_signed_multiplier_core_macros.svh =====
// Assertion macros shared by the multiplier RTL.
`ifndef BOOTH_SIGNED_MULTIPLIER_CORE_MACROS_SVH
`define BOOTH_SIGNED_MULTIPLIER_CORE_MACROS_SVH

// Clocked check that is suspended while reset is asserted.
`define BSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define BSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/bsm_pkg.sv =====
// Shared constants, Booth codes and the stage record of the Booth multiplier chain.
package bsm_pkg;

  localparam int OperandBits = 32;
  localparam int AccBits     = OperandBits + 1;
  localparam int ProductBits = 64;

  // Booth pair codes: {current multiplier bit, previous multiplier bit}.
  localparam logic [1:0] BoothSub = 2'b10;
  localparam logic [1:0] BoothAdd = 2'b01;

  typedef struct packed {
    logic                      valid;
    logic                      prev;
    logic signed [AccBits-1:0] mcand;
    logic signed [AccBits-1:0] acc;
    logic [OperandBits-1:0]    q;
  } bsm_stage_t;

endpackage

// ===== rtl/bsm_cell.sv =====
// One Booth step: add or subtract the multiplicand, then shift the accumulator and multiplier.
`include "booth_signed_multiplier_core_macros.svh"

module bsm_cell import bsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bsm_stage_t stage_i,
  output bsm_stage_t stage_o
);

  logic signed [AccBits:0] acc_ext;
  logic signed [AccBits:0] mcand_ext;
  logic signed [AccBits:0] sum;
  bsm_stage_t              stage_d;
  bsm_stage_t              stage_q;

  assign acc_ext   = {stage_i.acc[AccBits-1], stage_i.acc};
  assign mcand_ext = {stage_i.mcand[AccBits-1], stage_i.mcand};

  always_comb begin
    case ({stage_i.q[0], stage_i.prev})
      BoothSub: sum = acc_ext - mcand_ext;
      BoothAdd: sum = acc_ext + mcand_ext;
      default:  sum = acc_ext;
    endcase
  end

  // The sum carries one guard bit, so dropping its low bit is the arithmetic shift.
  always_comb begin
    stage_d       = stage_i;
    stage_d.prev  = stage_i.q[0];
    stage_d.acc   = sum[AccBits:1];
    stage_d.q     = {sum[0], stage_i.q[OperandBits-1:1]};
  end

  // Only the valid bit is cleared by reset; the data fields simply hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

  `BSM_ASSERT(a_valid_follows, stage_q.valid |-> $past(stage_i.valid), "cell valid without request")
  `BSM_ASSERT(a_prev_bit, stage_q.valid |-> stage_q.prev == $past(stage_i.q[0]), "prev bit lost")
  `BSM_ASSERT(a_mcand_moves, stage_q.valid |-> stage_q.mcand == $past(stage_i.mcand), "mcand lost")

endmodule

// ===== rtl/booth_signed_multiplier_core.sv =====
// A request accepted with start passes through one register per cell and then the output register
// before its product appears on product_o with done_o high.
// Throughput: one request per cycle; busy is always low and the receiver cannot stall.
// Reset clears the valid bits of every cell and the result strobe; data registers are not reset.
// Top level of the pipelined radix-2 Booth signed multiplier.
`include "booth_signed_multiplier_core_macros.svh"

module booth_signed_multiplier_core import bsm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            multiplicand_i,
  input  logic signed [31:0]            multiplier_i,
  output logic                          done_o,
  output logic signed [ProductBits-1:0] product_o
);

  bsm_stage_t                   chain [OperandBits+1];
  logic                         done_q;
  logic signed [ProductBits-1:0] product_d;
  logic signed [ProductBits-1:0] product_q;

  assign busy = 1'b0;

  // Only the low OperandBits bits of each operand are used; the multiplicand is sign-extended.
  always_comb begin
    chain[0].valid = start && !busy;
    chain[0].prev  = 1'b0;
    chain[0].mcand = AccBits'($signed(multiplicand_i[OperandBits-1:0]));
    chain[0].acc   = '0;
    chain[0].q     = multiplier_i[OperandBits-1:0];
  end

  for (genvar i = 0; i < OperandBits; i++) begin : g_cell
    bsm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  assign product_d = ProductBits'($signed({chain[OperandBits].acc, chain[OperandBits].q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[OperandBits].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    product_q <= product_d;
  end

  assign done_o    = done_q;
  assign product_o = product_q;

  `BSM_ASSERT(a_done_from_chain, done_q |-> $past(chain[OperandBits].valid), "stray strobe")
  `BSM_ASSERT(a_product_known, done_q |-> !$isunknown(product_q), "product has unknown bits")
  `BSM_ASSERT_ALWAYS(a_never_busy, !busy, "multiplier refused a request")

endmodule

// ===== dv/booth_product_checker.sv =====
// Checker that predicts and compares every product of the Booth multiplier.
`timescale 1ns / 1ps

module booth_product_checker import bsm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [31:0]            multiplicand_i,
  input  logic signed [31:0]            multiplier_i,
  input  logic                          done_o,
  input  logic signed [ProductBits-1:0] product_o,
  output int                            mismatches,
  output int                            outstanding,
  output int                            checked
);

  typedef struct {
    logic signed [OperandBits-1:0] mcand;
    logic signed [OperandBits-1:0] mplier;
    logic signed [ProductBits-1:0] product;
  } product_entry_t;

  product_entry_t awaited_products[$];

  // Radix-2 Booth recoding with an accumulator one bit wider than the operands,
  // so that subtracting the most negative multiplicand cannot overflow.
  function automatic logic signed [ProductBits-1:0] booth_product(
    input logic signed [OperandBits-1:0] mcand,
    input logic signed [OperandBits-1:0] mplier
  );
    logic signed [AccBits-1:0] acc;
    logic signed [AccBits-1:0] mcand_ext;
    logic [OperandBits-1:0]    q;
    logic                      prev;
    acc       = '0;
    mcand_ext = {mcand[OperandBits-1], mcand};
    q         = mplier;
    prev      = 1'b0;
    for (int step = 0; step < OperandBits; step++) begin
      case ({q[0], prev})
        BoothSub: acc = acc - mcand_ext;
        BoothAdd: acc = acc + mcand_ext;
        default: ;
      endcase
      prev = q[0];
      {acc, q} = {acc[AccBits-1], acc, q[OperandBits-1:1]};
    end
    return {acc[ProductBits-OperandBits-1:0], q};
  endfunction

  always @(posedge clk_i) begin
    product_entry_t entry;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_products.size() == 0) begin
          $display("%0t: unexpected product: expected none, actual %0d", $time, product_o);
          mismatches <= mismatches + 1;
        end else begin
          entry = awaited_products.pop_front();
          checked <= checked + 1;
          if (product_o !== entry.product) begin
            $display("%0t: product of %0d * %0d: expected %0d, actual %0d",
                     $time, entry.mcand, entry.mplier, entry.product, product_o);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy) begin
        entry.mcand   = multiplicand_i;
        entry.mplier  = multiplier_i;
        entry.product = booth_product(multiplicand_i, multiplier_i);
        awaited_products.push_back(entry);
      end
      outstanding <= awaited_products.size();
    end
  end

endmodule

// ===== dv/booth_signed_multiplier_core_tb.sv =====
// Testbench top: clock, reset, multiply requests and the final verdict.
`timescale 1ns / 1ps

module booth_signed_multiplier_core_tb import bsm_pkg::*;;

  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 40;
  localparam int PhaseRequests = 410;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic signed [31:0]            multiplicand_i;
  logic signed [31:0]            multiplier_i;
  logic                          done_o;
  logic signed [ProductBits-1:0] product_o;

  int mismatches;
  int outstanding;
  int checked;
  int requests;
  int cycles;

  always #6 clk_i = ~clk_i;

  booth_signed_multiplier_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .multiplicand_i(multiplicand_i),
    .multiplier_i  (multiplier_i),
    .done_o        (done_o),
    .product_o     (product_o)
  );

  booth_product_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .multiplicand_i(multiplicand_i),
    .multiplier_i  (multiplier_i),
    .done_o        (done_o),
    .product_o     (product_o),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .checked       (checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("booth_signed_multiplier_core verification failed");
      $finish;
    end
  end

  // Holds the request until it is taken; start stays high for a back-to-back request.
  task automatic issue(input logic [31:0] mcand, input logic [31:0] mplier);
    multiplicand_i <= mcand;
    multiplier_i   <= mplier;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    requests++;
  endtask

  task automatic idle_gap(input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Mix of extremes, small values, long bit runs, single set or clear bits and fully random words, since
  // Booth recoding only acts on the edges of runs of ones.
  function automatic logic [31:0] pick_operand();
    logic [31:0] value;
    logic        bit_now;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(5))
          0: value = 32'h0000_0000;
          1: value = 32'h0000_0001;
          2: value = 32'hFFFF_FFFF;
          3: value = 32'h8000_0000;
          4: value = 32'h7FFF_FFFF;
          default: value = 32'h8000_0001;
        endcase
      end
      1: value = 32'($signed($urandom_range(511)) - 256);
      2: begin
        bit_now = 1'($urandom_range(1));
        for (int i = 0; i < 32; i++) begin
          if ($urandom_range(7) == 0) bit_now = ~bit_now;
          value[i] = bit_now;
        end
      end
      3: begin
        value = 32'h1 << $urandom_range(31);
        if ($urandom_range(1) == 1) value = ~value;
      end
      default: value = $urandom();
    endcase
    return value;
  endfunction

  initial begin
    int idle_pct[4];
    idle_pct = '{0, 50, 0, 23};
    rst_ni         = 1'b0;
    start          = 1'b0;
    multiplicand_i = '0;
    multiplier_i   = '0;
    requests       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(32'h0000_0000, 32'h0000_0000);
    issue(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue(32'h8000_0000, 32'h8000_0000);
    issue(32'h8000_0000, 32'h7FFF_FFFF);
    issue(32'h7FFF_FFFF, 32'h8000_0000);
    issue(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(32'h8000_0000, 32'hFFFF_FFFF);
    issue(32'hFFFF_FFFF, 32'h8000_0000);
    issue(32'h0000_0001, 32'h8000_0000);
    issue(32'h8000_0000, 32'h0000_0001);
    issue(32'h0000_0000, 32'h8000_0000);
    issue(32'h8000_0000, 32'h0000_0000);
    issue(32'h5555_5555, 32'hAAAA_AAAA);
    issue(32'hAAAA_AAAA, 32'h5555_5555);
    issue(32'h8000_0001, 32'h8000_0001);
    issue(32'h1234_5678, 32'hFFFF_0000);
    issue(32'hFFFF_FFFE, 32'h0000_FFFF);
    issue(32'h0000_0003, 32'hFFFF_FFFD);
    issue(32'hDEAD_BEEF, 32'h0F0F_0F0F);
    issue(32'h7FFF_FFFF, 32'hFFFF_FFFF);

    foreach (idle_pct[phase]) begin
      repeat (PhaseRequests) begin
        idle_gap(idle_pct[phase]);
        issue(pick_operand(), pick_operand());
      end
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d multiply requests (directed corners, then four traffic phases).",
             requests);
    $display("Compared %0d products against the Booth prediction.", checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("booth_signed_multiplier_core verification clean");
    end else begin
      $display("booth_signed_multiplier_core verification failed");
    end
    $finish;
  end

endmodule
